// ===== rtl/lds_pkg.sv =====
package lds_pkg;

    localparam int STEP_PERIOD_MS = 10;
    localparam int DOWN_MARGIN    = 10;

    localparam int HALT_W  = 16;
    localparam int COUNT_W = 16;
    localparam int UP_W    = 16;
    localparam int EXTRA_W = 8;
    localparam int CFG_W   = 16;

    // Threshold widths: base = up + 2*extra, top adds halt, down adds up, halt and margin.
    localparam int BASE_W = 17;
    localparam int THR_W  = 18;

    // Reciprocal for the halt conversion; exact for every 16-bit value and any period up to 1000.
    localparam int    RECIP_SHIFT = 28;
    localparam int    RECIP_W     = 29;
    localparam longint RECIP_VAL  =
        ((64'd1 << RECIP_SHIFT) + STEP_PERIOD_MS - 1) / STEP_PERIOD_MS;
    localparam int    PROD_W      = HALT_W + RECIP_W;

    typedef enum logic [0:0] {
        OP_TICK     = 1'b0,
        OP_SET_HALT = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        CFG_UP_STEPS       = 1'b0,
        CFG_EXTRA_TRIGGERS = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_SLEEP = 3'd0,
        PH_UP    = 3'd1,
        PH_TOP   = 3'd2,
        PH_DOWN  = 3'd3,
        PH_ERROR = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        MV_NONE = 2'd0,
        MV_UP   = 2'd1,
        MV_DOWN = 2'd2,
        MV_STOP = 2'd3
    } move_t;

    typedef enum logic [1:0] {
        EN_NONE = 2'd0,
        EN_ON   = 2'd1,
        EN_OFF  = 2'd2
    } enable_t;

    typedef struct packed {
        logic              opcode;
        logic [HALT_W-1:0] halt_time_ms;
        logic              switch_closed;
        logic              motor_ok;
        logic              reinit_ok;
    } item_t;

    typedef struct packed {
        logic [1:0] move_cmd;
        logic [1:0] enable_cmd;
        logic       reinit_cmd;
        logic [2:0] phase;
        logic       idle;
    } result_t;

endpackage

// ===== rtl/lds_in_if.sv =====
interface lds_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] halt_time_ms;
    logic        switch_closed;
    logic        motor_ok;
    logic        reinit_ok;

    modport source (
        output valid, opcode, halt_time_ms, switch_closed, motor_ok, reinit_ok,
        input  ready
    );

    modport sink (
        input  valid, opcode, halt_time_ms, switch_closed, motor_ok, reinit_ok,
        output ready
    );
endinterface

interface lds_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] move_cmd;
    logic [1:0] enable_cmd;
    logic       reinit_cmd;
    logic [2:0] phase;
    logic       idle;

    modport source (
        output valid, move_cmd, enable_cmd, reinit_cmd, phase, idle,
        input  ready
    );

    modport sink (
        input  valid, move_cmd, enable_cmd, reinit_cmd, phase, idle,
        output ready
    );
endinterface

// ===== rtl/lds_in_stage.sv =====
module lds_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lds_pkg::item_t in_item,
    output logic           item_valid,
    input  logic           item_take,
    output lds_pkg::item_t item
);
    import lds_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// ===== rtl/lds_halt_conv.sv =====
module lds_halt_conv (
    input  logic [lds_pkg::HALT_W-1:0] halt_time_ms,
    output logic [lds_pkg::HALT_W-1:0] halt_steps
);
    import lds_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic [PROD_W-1:0] prod;

    // Division by the step period as a multiply by its rounded-up reciprocal.
    assign prod       = PROD_W'(halt_time_ms) * PROD_W'(RECIP);
    assign halt_steps = prod[RECIP_SHIFT +: HALT_W];
endmodule

// ===== rtl/lds_ctrl.sv =====
module lds_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  lds_pkg::item_t              item,
    input  logic [lds_pkg::HALT_W-1:0]  halt_conv,
    input  logic [lds_pkg::UP_W-1:0]    up_steps,
    input  logic [lds_pkg::EXTRA_W-1:0] extra_triggers,
    output logic                        item_take,
    output logic                        res_valid,
    input  logic                        res_ready,
    output lds_pkg::result_t            res
);
    import lds_pkg::*;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [HALT_W-1:0]   halt_reg;
    logic [HALT_W-1:0]   halt_next;
    logic                res_valid_reg;
    result_t             res_reg;
    result_t             res_next;

    logic [BASE_W-1:0]   base;
    logic [THR_W-1:0]    thr_top;
    logic [THR_W-1:0]    thr_down;
    logic [COUNT_W-1:0]  count_inc;
    phase_t              phase_eff;
    move_t               mv;
    enable_t             en;
    logic                ri;

    assign item_take = item_valid && (!res_valid_reg || res_ready);

    assign base     = BASE_W'(up_steps) + (BASE_W'(extra_triggers) << 1);
    assign thr_top  = THR_W'(base) + THR_W'(halt_reg);
    assign thr_down = THR_W'(base) + THR_W'(up_steps) + THR_W'(halt_reg) + THR_W'(DOWN_MARGIN);
    assign count_inc = (count_reg == {COUNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        halt_next  = halt_reg;
        mv         = MV_NONE;
        en         = EN_NONE;
        ri         = 1'b0;
        phase_eff  = item.motor_ok ? phase_reg : PH_ERROR;
        if (item.opcode == OP_SET_HALT)
        begin
            halt_next  = halt_conv;
            count_next = '0;
        end
        else
        begin
            phase_next = phase_eff;
            unique case (phase_eff)
                PH_ERROR:
                begin
                    ri = 1'b1;
                    if (item.reinit_ok)
                    begin
                        en         = EN_OFF;
                        halt_next  = '0;
                        phase_next = PH_SLEEP;
                    end
                end
                PH_UP:
                begin
                    if (BASE_W'(count_reg) > base)
                    begin
                        mv         = MV_STOP;
                        phase_next = PH_TOP;
                    end
                    else if (!item.switch_closed)
                    begin
                        count_next = count_inc;
                    end
                end
                PH_TOP:
                begin
                    if (THR_W'(count_reg) > thr_top)
                    begin
                        mv         = MV_DOWN;
                        phase_next = PH_DOWN;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                PH_DOWN:
                begin
                    if (item.switch_closed || THR_W'(count_reg) > thr_down)
                    begin
                        mv         = MV_STOP;
                        en         = EN_OFF;
                        halt_next  = '0;
                        phase_next = PH_SLEEP;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_SLEEP;
                    if (halt_reg != '0)
                    begin
                        en         = EN_ON;
                        mv         = MV_UP;
                        phase_next = PH_UP;
                    end
                end
            endcase
        end
        res_next.move_cmd   = mv;
        res_next.enable_cmd = en;
        res_next.reinit_cmd = ri;
        res_next.phase      = phase_next;
        res_next.idle       = (phase_next == PH_SLEEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SLEEP;
            count_reg     <= '0;
            halt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                halt_reg  <= halt_next;
            end
            if (item_take)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
endmodule

// ===== rtl/lift_dispense_sequencer_core.sv =====
// Channel  Dir  Beat content
// in_ch    in   opcode, halt_time_ms, switch_closed, motor_ok, reinit_ok
// out_ch   out  move_cmd, enable_cmd, reinit_cmd, phase, idle
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// Every input beat produces exactly one output beat, held in the input register
// and then in the result register. One beat is accepted per cycle while the
// output is not stalled; the input register, step logic and result register
// form a two-stage pipeline. Reset puts the sequencer in sleep with zero step
// count, halt and configuration registers. An output stall holds the result
// register and stops the input once the input register is also full.
module lift_dispense_sequencer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    lds_in_if.sink                       in_ch,
    lds_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [lds_pkg::CFG_W-1:0]    cfg_data
);
    import lds_pkg::*;

    logic [UP_W-1:0]    up_steps_reg;
    logic [EXTRA_W-1:0] extra_triggers_reg;
    item_t              in_item;
    item_t              item;
    logic               item_valid;
    logic               item_take;
    logic [HALT_W-1:0]  halt_conv;
    result_t            res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_steps_reg       <= '0;
            extra_triggers_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_UP_STEPS:       up_steps_reg       <= cfg_data[UP_W-1:0];
                CFG_EXTRA_TRIGGERS: extra_triggers_reg <= cfg_data[EXTRA_W-1:0];
                default:            up_steps_reg       <= up_steps_reg;
            endcase
        end
    end

    assign in_item.opcode        = in_ch.opcode;
    assign in_item.halt_time_ms  = in_ch.halt_time_ms;
    assign in_item.switch_closed = in_ch.switch_closed;
    assign in_item.motor_ok      = in_ch.motor_ok;
    assign in_item.reinit_ok     = in_ch.reinit_ok;

    lds_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    lds_halt_conv u_halt_conv (
        .halt_time_ms (item.halt_time_ms),
        .halt_steps   (halt_conv)
    );

    lds_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .halt_conv      (halt_conv),
        .up_steps       (up_steps_reg),
        .extra_triggers (extra_triggers_reg),
        .item_take      (item_take),
        .res_valid      (out_ch.valid),
        .res_ready      (out_ch.ready),
        .res            (res)
    );

    assign out_ch.move_cmd   = res.move_cmd;
    assign out_ch.enable_cmd = res.enable_cmd;
    assign out_ch.reinit_cmd = res.reinit_cmd;
    assign out_ch.phase      = res.phase;
    assign out_ch.idle       = res.idle;
endmodule

// ===== rtl/lds_checker.sv =====
module lds_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] move_cmd,
    input logic [1:0] enable_cmd,
    input logic       reinit_cmd,
    input logic [2:0] phase,
    input logic       idle
);
    import lds_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idle == (phase == PH_SLEEP)))
        else $error("idle disagrees with phase");

    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reinit_cmd |-> move_cmd == MV_NONE
            && (phase == PH_ERROR || phase == PH_SLEEP))
        else $error("reinitialise outside error handling");

    a_enable_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && enable_cmd == EN_ON |-> move_cmd == MV_UP && phase == PH_UP)
        else $error("driver enabled without upward start");

    a_disable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && enable_cmd == EN_OFF |-> phase == PH_SLEEP)
        else $error("driver disabled without return to sleep");
endmodule

bind lift_dispense_sequencer_core lds_checker u_lds_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .move_cmd   (out_ch.move_cmd),
    .enable_cmd (out_ch.enable_cmd),
    .reinit_cmd (out_ch.reinit_cmd),
    .phase      (out_ch.phase),
    .idle       (out_ch.idle)
);
